// File: design/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by rotation_matrix_to_quaternion_core.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds on a rising clock edge, off in reset.
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// File: design/rmq_pkg.sv
// -----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion core.
// -----------------------------------------------------------------------------
package rmq_pkg;
  localparam int FracBits = 16;
  localparam int DataW    = 18;
  localparam int RadW     = 21;                 // radicand, signed; negative values are treated as zero
  localparam int SqW      = RadW + FracBits;    // radicand scaled by 2^FracBits
  localparam int RootW    = (SqW + 1) / 2;      // floor(sqrt) width
  localparam int SW       = RootW + 1;          // S = 2 * root
  localparam int NumW     = 20;                 // |numerator| magnitude
  localparam int DvdW     = NumW + FracBits;    // dividend width
  localparam int SqSteps  = RootW;              // one root bit per cell
  localparam int DivSteps = DvdW;               // one quotient bit per cell
  localparam int Depth    = SqSteps + DivSteps;
  localparam logic [DataW-1:0] Lim = DataW'(1 << FracBits);

  localparam logic [1:0] BrTrace = 2'd0;
  localparam logic [1:0] BrX     = 2'd1;
  localparam logic [1:0] BrY     = 2'd2;
  localparam logic [1:0] BrZ     = 2'd3;

  // Payload carried along the chain: three off-diagonal numerators
  // (sign + magnitude) and the branch code.
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][NumW-1:0]  mag;
    logic [1:0]            branch;
  } side_t;

  // Square-root cell state.
  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [SqW-1:0]   val;
    logic [RootW-1:0] root;
  } sq_t;

  // Divider cell state: three lanes share the divisor.
  typedef struct packed {
    logic [SW-1:0]              s;
    logic [2:0][DvdW-1:0]       rem;
    logic [2:0][DvdW-1:0]       quo;
  } dv_t;
endpackage

// File: design/rotation_matrix_to_quaternion_core.sv
// -----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a Q1.16 rotation matrix to a saturated quaternion.
// -----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit first)                 tuser
// s_axis   in   r00 r01 r02 r10 r11 r12 r20 r21 r22    -
// m_axis   out  qw qx qy qz (18 bits each)            branch_taken
//
// One matrix is taken every cycle while m_axis is not stalled. The path is one
// entry stage, a chain of 19 square-root cells (one root bit each), a chain
// of 36 divider cells (one quotient bit each, three lanes) and an output
// register. A stall on m_axis freezes the whole chain and drops s_axis_tready
// until the waiting result transfers; with m_axis_tready high, matrices flow
// back to back. Reset clears the valid bits only.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // r00 r01 r02 r10 r11 r12 r20 r21 r22, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // qw qx qy qz
  output logic [1:0]   m_axis_tuser   // branch_taken
);
  import rmq_pkg::*;

  logic en;
  logic signed [DataW-1:0] a [9];
  logic signed [RadW-1:0]  tr, rx, ry, rz, rad;
  logic signed [NumW:0]    n [6];   // 21-bit signed sums/differences
  logic signed [NumW:0]    nsel [3];
  logic [1:0]              br;
  side_t                   side_d;

  // Hold everything when the output register is full and not drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      a[k] = s_axis_tdata[k*DataW +: DataW];
    end
    tr = RadW'(a[0]) + RadW'(a[4]) + RadW'(a[8]);
    rx = RadW'(a[0]) - RadW'(a[4]) - RadW'(a[8]);
    ry = RadW'(a[4]) - RadW'(a[0]) - RadW'(a[8]);
    rz = RadW'(a[8]) - RadW'(a[0]) - RadW'(a[4]);
    n[0] = (NumW+1)'(a[7]) - (NumW+1)'(a[5]); // r21 - r12
    n[1] = (NumW+1)'(a[2]) - (NumW+1)'(a[6]); // r02 - r20
    n[2] = (NumW+1)'(a[3]) - (NumW+1)'(a[1]); // r10 - r01
    n[3] = (NumW+1)'(a[1]) + (NumW+1)'(a[3]); // r01 + r10
    n[4] = (NumW+1)'(a[2]) + (NumW+1)'(a[6]); // r02 + r20
    n[5] = (NumW+1)'(a[5]) + (NumW+1)'(a[7]); // r12 + r21
    // Pick the branch; the three non-main components fill slots in order.
    if (tr > 0) begin
      br = BrTrace; rad = tr;
      nsel[0] = n[0]; nsel[1] = n[1]; nsel[2] = n[2];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      br = BrX; rad = rx;
      nsel[0] = n[0]; nsel[1] = n[3]; nsel[2] = n[4];
    end else if (a[4] > a[8]) begin
      br = BrY; rad = ry;
      nsel[0] = n[1]; nsel[1] = n[3]; nsel[2] = n[5];
    end else begin
      br = BrZ; rad = rz;
      nsel[0] = n[2]; nsel[1] = n[4]; nsel[2] = n[5];
    end
    rad = rad + RadW'(1 << FracBits);
    side_d.branch = br;
    for (int l = 0; l < 3; l++) begin
      side_d.neg[l] = nsel[l][NumW];
      side_d.mag[l] = NumW'(nsel[l][NumW] ? -nsel[l] : nsel[l]);
    end
  end

  // Entry stage.
  logic  vld0_q;
  sq_t   sq0_q;
  side_t side0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq0_q.rem  <= '0;
      sq0_q.root <= '0;
      // Non-positive radicand counts as zero.
      sq0_q.val  <= rad[RadW-1] ? '0 : {rad[RadW-2:0], {FracBits{1'b0}}, 1'b0} >> 1;
      side0_q    <= side_d;
    end
  end

  // Square-root chain.
  logic  sv [SqSteps+1];
  sq_t   ss [SqSteps+1];
  side_t sd [SqSteps+1];
  assign sv[0] = vld0_q;
  assign ss[0] = sq0_q;
  assign sd[0] = side0_q;
  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk_i, .rst_ni, .step_i(6'(g)), .en_i(en),
      .vld_i(sv[g]), .sq_i(ss[g]), .side_i(sd[g]),
      .vld_o(sv[g+1]), .sq_o(ss[g+1]), .side_o(sd[g+1])
    );
  end

  // Divider chain.
  logic             dvv [DivSteps+1];
  dv_t              dvs [DivSteps+1];
  side_t            dsd [DivSteps+1];
  logic [RootW-1:0] drt [DivSteps+1];
  assign dvv[0]   = sv[SqSteps];
  assign dvs[0].s = {ss[SqSteps].root, 1'b0};
  assign dvs[0].rem = '0;
  assign dvs[0].quo = '0;
  assign dsd[0]   = sd[SqSteps];
  assign drt[0]   = ss[SqSteps].root;
  for (genvar g = 0; g < DivSteps; g++) begin : g_dv
    rmq_div_cell u_cell (
      .clk_i, .rst_ni, .step_i(6'(g)), .en_i(en),
      .vld_i(dvv[g]), .dv_i(dvs[g]), .side_i(dsd[g]), .root_i(drt[g]),
      .vld_o(dvv[g+1]), .dv_o(dvs[g+1]), .side_o(dsd[g+1]), .root_o(drt[g+1])
    );
  end

  // Finish: saturate, restore signs, place the main component.
  dv_t              fdv;
  side_t            fsd;
  logic [RootW-1:0] froot;
  logic [DataW-1:0] comp [3];
  logic [DataW-1:0] mainc;
  logic [DataW-1:0] q [4];
  logic [DvdW-1:0]  qm;
  assign fdv   = dvs[DivSteps];
  assign fsd   = dsd[DivSteps];
  assign froot = drt[DivSteps];
  always_comb begin
    mainc = ((froot >> 1) > RootW'(Lim)) ? Lim : DataW'(froot >> 1);
    for (int l = 0; l < 3; l++) begin
      if (fdv.s == '0) begin
        qm = (fsd.mag[l] == '0) ? '0 : DvdW'(Lim);
      end else begin
        qm = fdv.quo[l];
      end
      comp[l] = (qm > DvdW'(Lim)) ? Lim : DataW'(qm);
      if (fsd.neg[l]) comp[l] = -comp[l];
    end
    case (fsd.branch)
      BrTrace: begin q[0] = mainc; q[1] = comp[0]; q[2] = comp[1]; q[3] = comp[2]; end
      BrX:     begin q[0] = comp[0]; q[1] = mainc; q[2] = comp[1]; q[3] = comp[2]; end
      BrY:     begin q[0] = comp[0]; q[1] = comp[1]; q[2] = mainc; q[3] = comp[2]; end
      default: begin q[0] = comp[0]; q[1] = comp[1]; q[2] = comp[2]; q[3] = mainc; end
    endcase
  end

  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvv[DivSteps];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {q[3], q[2], q[1], q[0]};
      m_axis_tuser <= fsd.branch;
    end
  end
  assign m_axis_tvalid = out_vld_q;

  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_CLK(a_ready_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_CLK(a_main_pos, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser == BrTrace |-> !m_axis_tdata[17])
  `ASSERT_NEVER(a_stall_blocks, clk_i, rst_ni,
    s_axis_tready && m_axis_tvalid && !m_axis_tready)
endmodule

// File: design/rmq_sqrt_cell.sv
// -----------------------------------------------------------------------------
// rmq_sqrt_cell
// One step of a restoring square root: settles one root bit per cycle while enabled.
// -----------------------------------------------------------------------------
module rmq_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        step_i,
  input  logic              en_i,
  input  logic              vld_i,
  input  rmq_pkg::sq_t      sq_i,
  input  rmq_pkg::side_t    side_i,
  output logic              vld_o,
  output rmq_pkg::sq_t      sq_o,
  output rmq_pkg::side_t    side_o
);
  import rmq_pkg::*;

  logic           vld_q;
  sq_t            sq_q, sq_d;
  side_t          side_q;
  logic [SqW+1:0] trial;
  logic [SqW+1:0] cur;
  int unsigned    sh;

  // Bring in the next two radicand bits, try root*4+1.
  always_comb begin
    sh    = 2 * (RootW - 1 - int'(step_i));
    cur   = {sq_i.rem, 2'b00} | (SqW+2)'((sq_i.val >> sh) & SqW'(3));
    trial = {sq_i.root, 2'b01};
    sq_d  = sq_i;
    if (cur >= trial) begin
      sq_d.rem  = SqW'(cur - trial);
      sq_d.root = {sq_i.root[RootW-2:0], 1'b1};
    end else begin
      sq_d.rem  = SqW'(cur);
      sq_d.root = {sq_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign sq_o   = sq_q;
  assign side_o = side_q;
endmodule

// File: design/rmq_div_cell.sv
// -----------------------------------------------------------------------------
// rmq_div_cell
// One step of three restoring dividers sharing a divisor: one quotient bit.
// -----------------------------------------------------------------------------
module rmq_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        step_i,
  input  logic              en_i,
  input  logic              vld_i,
  input  rmq_pkg::dv_t      dv_i,
  input  rmq_pkg::side_t    side_i,
  input  logic [rmq_pkg::RootW-1:0] root_i,
  output logic              vld_o,
  output rmq_pkg::dv_t      dv_o,
  output rmq_pkg::side_t    side_o,
  output logic [rmq_pkg::RootW-1:0] root_o
);
  import rmq_pkg::*;

  logic             vld_q;
  dv_t              dv_q, dv_d;
  side_t            side_q;
  logic [RootW-1:0] root_q;
  logic [DvdW:0]    cur [3];

  // Shift in the next dividend bit, subtract S if it fits.
  always_comb begin
    dv_d = dv_i;
    for (int l = 0; l < 3; l++) begin
      if (int'(step_i) < NumW) begin
        cur[l] = {dv_i.rem[l], side_i.mag[l][NumW - 1 - int'(step_i)]};
      end else begin
        cur[l] = {dv_i.rem[l], 1'b0};
      end
      if (cur[l] >= (DvdW+1)'(dv_i.s)) begin
        dv_d.rem[l] = DvdW'(cur[l] - (DvdW+1)'(dv_i.s));
        dv_d.quo[l] = {dv_i.quo[l][DvdW-2:0], 1'b1};
      end else begin
        dv_d.rem[l] = DvdW'(cur[l]);
        dv_d.quo[l] = {dv_i.quo[l][DvdW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q   <= dv_d;
      side_q <= side_i;
      root_q <= root_i;
    end
  end

  assign vld_o  = vld_q;
  assign dv_o   = dv_q;
  assign side_o = side_q;
  assign root_o = root_q;
endmodule
